// ===== rtl/core/lbc_pkg.sv =====
// shared types, constants and round functions of the 64/128 block cipher
package lbc_pkg;

    localparam int BLK_W     = 64;
    localparam int HALF_W    = 32;
    localparam int KEY_W     = 64;
    localparam int RC_W      = 5;
    localparam int CFG_IDX_W = 2;
    localparam int KS_ROT    = 13;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_UPPER = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOWER = CFG_IDX_W'(1);

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'h3, 4'hf, 4'he, 4'h1, 4'h0, 4'ha, 4'h5, 4'h8,
        4'hc, 4'h4, 4'hb, 4'h2, 4'h9, 4'h7, 4'h6, 4'hd
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h4, 4'h3, 4'hb, 4'h0, 4'h9, 4'h6, 4'he, 4'hd,
        4'h7, 4'hc, 4'h5, 4'ha, 4'h8, 4'hf, 4'h2, 4'h1
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PREP,
        ST_ROUND,
        ST_FINISH
    } lbc_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic key_init;
        logic key_step;
        logic round_en;
        logic out_load;
    } lbc_cmd_t;

    // nibble-wise s-box over one half
    function automatic logic [HALF_W-1:0] sub_word(input logic [HALF_W-1:0] x,
                                                   input logic inv);
        logic [HALF_W-1:0] z;
        z = '0;
        for (int n = 0; n < HALF_W / 4; n++) begin
            z[n*4 +: 4] = inv ? SBOX_INV[x[n*4 +: 4]] : SBOX_FWD[x[n*4 +: 4]];
        end
        return z;
    endfunction

    function automatic logic [HALF_W-1:0] rotl32(input logic [HALF_W-1:0] x,
                                                 input int s);
        return (x << s) | (x >> (HALF_W - s));
    endfunction

    function automatic logic [HALF_W-1:0] rotr32(input logic [HALF_W-1:0] x,
                                                 input int s);
        return (x >> s) | (x << (HALF_W - s));
    endfunction

    // one forward round, result already swapped
    function automatic logic [BLK_W-1:0] enc_round(input logic [BLK_W-1:0] b,
                                                   input logic [KEY_W-1:0] k);
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] l1;
        logic [HALF_W-1:0] r1;
        l  = b[BLK_W-1:HALF_W];
        r  = b[HALF_W-1:0];
        s  = sub_word(r, 1'b0);
        l1 = rotl32(s ^ l ^ k[HALF_W-1:0], 3);
        r1 = rotr32(s ^ l1 ^ k[KEY_W-1:HALF_W], 7);
        return {r1, l1};
    endfunction

    // one inverse round
    function automatic logic [BLK_W-1:0] dec_round(input logic [BLK_W-1:0] b,
                                                   input logic [KEY_W-1:0] k);
        logic [HALF_W-1:0] l;
        logic [HALF_W-1:0] r;
        logic [HALF_W-1:0] r1;
        logic [HALF_W-1:0] l1;
        l  = b[HALF_W-1:0];
        r  = b[BLK_W-1:HALF_W];
        r1 = rotl32(r, 7) ^ l ^ k[KEY_W-1:HALF_W];
        l1 = rotr32(l, 3) ^ r1 ^ k[HALF_W-1:0];
        return {l1, sub_word(r1, 1'b1)};
    endfunction

    // one key schedule step on {upper, lower}
    function automatic logic [2*KEY_W-1:0] key_next(input logic [2*KEY_W-1:0] k,
                                                    input logic [RC_W-1:0] rc);
        logic [2*KEY_W-1:0] rot;
        logic [KEY_W-1:0]   lo;
        rot = (k << KS_ROT) | (k >> (2*KEY_W - KS_ROT));
        lo  = rot[KEY_W-1:0];
        lo[7:4] = SBOX_FWD[lo[7:4]];
        lo[3:0] = SBOX_FWD[lo[3:0]];
        lo[KEY_W-1 -: RC_W] = lo[KEY_W-1 -: RC_W] ^ rc;
        return {rot[2*KEY_W-1:KEY_W], lo};
    endfunction

endpackage

// ===== rtl/core/lbc_blk_if.sv =====
// input channel: operation and block
interface lbc_blk_if
    import lbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [BLK_W-1:0]  block_in;

    modport source (output valid, mode, block_in, input ready);
    modport sink   (input valid, mode, block_in, output ready);
endinterface

// ===== rtl/core/lbc_res_if.sv =====
// result channel: processed block
interface lbc_res_if
    import lbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BLK_W-1:0]  block_out;

    modport source (output valid, block_out, input ready);
    modport sink   (input valid, block_out, output ready);
endinterface

// ===== rtl/core/lbc_ctrl.sv =====
// sequencer: key expansion, round iteration and output slot
module lbc_ctrl
    import lbc_pkg::*;
#(
    parameter int ROUNDS = 31,
    parameter int IDX_W  = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_mode,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  logic              cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    output lbc_cmd_t          cmd,
    output logic [IDX_W-1:0]  step_idx,
    output logic [IDX_W-1:0]  rd_idx
);

    localparam int                EXP_LAST_I = (ROUNDS > 1) ? ROUNDS - 2 : 0;
    localparam logic [IDX_W-1:0]  EXP_LAST   = IDX_W'(EXP_LAST_I);
    localparam logic [IDX_W-1:0]  RND_LAST   = IDX_W'(ROUNDS - 1);
    localparam logic              HAS_EXPAND = (ROUNDS > 1);

    lbc_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              mode_reg, mode_next;
    logic              keys_valid_reg, keys_valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              accept;
    logic              slot_free;
    logic [IDX_W-1:0]  nxt_idx;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign slot_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mode_next  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    mode_next = in_mode;
                    cnt_next  = '0;
                    state_next = (!keys_valid_reg && HAS_EXPAND) ? ST_EXPAND : ST_PREP;
                end
            end
            ST_EXPAND:
            begin
                if (cnt_reg == EXP_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_PREP;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_PREP:
            begin
                cnt_next   = '0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cnt_reg == RND_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and flags
    always_comb
    begin
        cmd.load     = accept;
        cmd.key_init = accept && !keys_valid_reg;
        cmd.key_step = (state_reg == ST_EXPAND);
        cmd.round_en = (state_reg == ST_ROUND);
        cmd.out_load = (state_reg == ST_FINISH) && slot_free;
        in_ready     = (state_reg == ST_IDLE);
        out_valid    = out_valid_reg;
        step_idx     = cnt_reg;
        // no prefetch past the last round, the index stays inside the memory
        nxt_idx      = (state_reg == ST_ROUND && cnt_reg != RND_LAST) ? cnt_reg + 1'b1 : '0;
        rd_idx       = mode_reg ? RND_LAST - nxt_idx : nxt_idx;

        keys_valid_next = keys_valid_reg;
        if (cfg_wr_en && (cfg_index == REG_KEY_UPPER || cfg_index == REG_KEY_LOWER))
        begin
            keys_valid_next = 1'b0;
        end
        else if (cmd.key_init)
        begin
            keys_valid_next = 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            mode_reg       <= 1'b0;
            keys_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            mode_reg       <= mode_next;
            keys_valid_reg <= keys_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

endmodule

// ===== rtl/core/lbc_dp.sv =====
// datapath: key registers, key schedule, round key memory, round unit
module lbc_dp
    import lbc_pkg::*;
#(
    parameter int ROUNDS = 31,
    parameter int IDX_W  = 5
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data,
    input  lbc_cmd_t             cmd,
    input  logic [IDX_W-1:0]     step_idx,
    input  logic [IDX_W-1:0]     rd_idx,
    input  logic                 in_mode,
    input  logic [BLK_W-1:0]     in_block,
    output logic [BLK_W-1:0]     out_block
);

    logic [KEY_W-1:0]   key_upper_reg;
    logic [KEY_W-1:0]   key_lower_reg;
    logic [KEY_W-1:0]   ks_hi_reg, ks_hi_next;
    logic [KEY_W-1:0]   ks_lo_reg, ks_lo_next;
    logic [2*KEY_W-1:0] ks_step;
    logic [KEY_W-1:0]   rk_mem [ROUNDS];
    logic [KEY_W-1:0]   rk_q_reg;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    logic [KEY_W-1:0]   mem_wd;
    logic [BLK_W-1:0]   blk_reg, blk_next;
    logic               mode_reg;
    logic [BLK_W-1:0]   out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == REG_KEY_UPPER)
            begin
                key_upper_reg <= cfg_data;
            end
            else if (cfg_index == REG_KEY_LOWER)
            begin
                key_lower_reg <= cfg_data;
            end
        end
    end

    // key schedule
    always_comb
    begin
        ks_step    = key_next({ks_hi_reg, ks_lo_reg}, RC_W'(step_idx));
        ks_hi_next = ks_hi_reg;
        ks_lo_next = ks_lo_reg;
        mem_we     = 1'b0;
        mem_wa     = step_idx + 1'b1;
        mem_wd     = ks_step[KEY_W-1:0];
        if (cmd.key_init)
        begin
            ks_hi_next = key_upper_reg;
            ks_lo_next = key_lower_reg;
            mem_we     = 1'b1;
            mem_wa     = '0;
            mem_wd     = key_lower_reg;
        end
        else if (cmd.key_step)
        begin
            ks_hi_next = ks_step[2*KEY_W-1:KEY_W];
            ks_lo_next = ks_step[KEY_W-1:0];
            mem_we     = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        ks_hi_reg <= ks_hi_next;
        ks_lo_reg <= ks_lo_next;
    end

    // round key memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rk_mem[mem_wa] <= mem_wd;
        end
        rk_q_reg <= rk_mem[rd_idx];
    end

    // round unit
    always_comb
    begin
        blk_next = blk_reg;
        if (cmd.load)
        begin
            blk_next = in_block;
        end
        else if (cmd.round_en)
        begin
            blk_next = mode_reg ? dec_round(blk_reg, rk_q_reg) : enc_round(blk_reg, rk_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        blk_reg <= blk_next;
        if (cmd.load)
        begin
            mode_reg <= in_mode;
        end
        if (cmd.out_load)
        begin
            out_reg <= blk_reg;
        end
    end

    assign out_block = out_reg;

endmodule

// ===== rtl/core/lightweight_block_cipher_64_128.sv =====
// top level of the 64-bit block, 128-bit key feistel-like cipher
//
// One block is encrypted (mode 0) or decrypted (mode 1) per input beat under
// the 128-bit key held in two write-only registers, key_upper at index 0 and
// key_lower at index 1. The round keys live in a memory of ROUNDS entries with
// one write port and one registered read port. After any key write, the next
// block first rebuilds that memory one round key per cycle; later blocks reuse
// it. A block then goes from its input beat to its result beat in these steps:
// the beat is taken, the first round key is prefetched from the memory, one
// round runs per cycle through the shared round unit, and the result moves
// into the output register. The memory port, read one key per cycle, sets the
// round pace. A result waits in the output register while the next block is
// taken and processed; only its own output move waits for the slot.
module lightweight_block_cipher_64_128
    import lbc_pkg::*;
#(
    parameter int ROUNDS = 31
) (
    input  logic                 clk,
    input  logic                 rst_n,
    lbc_blk_if.sink              blk,
    lbc_res_if.source            res,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [KEY_W-1:0]     cfg_data
);

    // round counter and memory index width
    localparam int IDX_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    lbc_cmd_t          cmd;
    logic [IDX_W-1:0]  step_idx;
    logic [IDX_W-1:0]  rd_idx;

    // sequencer
    lbc_ctrl #(
        .ROUNDS (ROUNDS),
        .IDX_W  (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (blk.valid),
        .in_mode   (blk.mode),
        .in_ready  (blk.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cmd       (cmd),
        .step_idx  (step_idx),
        .rd_idx    (rd_idx)
    );

    // key schedule, round key memory and round unit
    lbc_dp #(
        .ROUNDS (ROUNDS),
        .IDX_W  (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .step_idx  (step_idx),
        .rd_idx    (rd_idx),
        .in_mode   (blk.mode),
        .in_block  (blk.block_in),
        .out_block (res.block_out)
    );

endmodule

// ===== rtl/core/lbc_checker.sv =====
// port-level checks of the cipher, bound to the top level
module lbc_checker
    import lbc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [BLK_W-1:0] out_block
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped before taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_block))
        else $error("result beat changed while stalled");

    // one block at a time
    a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second block taken while busy");

    // a result never appears right after an input beat
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result beat too early");

endmodule

bind lightweight_block_cipher_64_128 lbc_checker u_lbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (blk.valid),
    .in_ready  (blk.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_block (res.block_out)
);

// ===== tb/sv/lightweight_block_cipher_64_128_test.sv =====
// self-checking testbench of the 64/128 block cipher: predicted blocks vs. dut under random flow
`timescale 1ns / 1ps

module lightweight_block_cipher_64_128_test
    import lbc_pkg::*;
();

    localparam int N_ROUNDS    = 31;
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 142;
    localparam int HOLD_CYCLES = 400;

    // operation codes on the mode field
    localparam logic OP_ENC = 1'b0;
    localparam logic OP_DEC = 1'b1;

    // register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

    localparam logic [BLK_W-1:0] ALL_ONES = {BLK_W{1'b1}};

    // 4-bit substitution and its inverse
    localparam logic [3:0] NIB_FWD [16] = '{
        4'h3, 4'hf, 4'he, 4'h1, 4'h0, 4'ha, 4'h5, 4'h8,
        4'hc, 4'h4, 4'hb, 4'h2, 4'h9, 4'h7, 4'h6, 4'hd
    };
    localparam logic [3:0] NIB_INV [16] = '{
        4'h4, 4'h3, 4'hb, 4'h0, 4'h9, 4'h6, 4'he, 4'hd,
        4'h7, 4'hc, 4'h5, 4'ha, 4'h8, 4'hf, 4'h2, 4'h1
    };

    // expected cipher blocks, predicted from the key registers at input time
    class cipher_scoreboard;
        logic [KEY_W-1:0] key_hi;
        logic [KEY_W-1:0] key_lo;
        logic [KEY_W-1:0] round_keys [N_ROUNDS];
        bit               keys_fresh;
        logic [BLK_W-1:0] expected_blocks [$];
        int               errors;

        function new();
            key_hi     = '0;
            key_lo     = '0;
            keys_fresh = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] val);
            if (idx == REG_KEY_UPPER)
            begin
                key_hi     = val;
                keys_fresh = 1'b0;
            end
            else if (idx == REG_KEY_LOWER)
            begin
                key_lo     = val;
                keys_fresh = 1'b0;
            end
        endfunction

        // round key 0 is the lower key half, the rest come from the 128-bit rotation
        function void build_round_keys();
            logic [2*KEY_W-1:0] k;
            logic [KEY_W-1:0]   lo;
            k = {key_hi, key_lo};
            round_keys[0] = key_lo;
            for (int r = 0; r < N_ROUNDS - 1; r++)
            begin
                k  = {k[2*KEY_W-14:0], k[2*KEY_W-1 -: 13]};
                lo = k[KEY_W-1:0];
                lo[7:4] = NIB_FWD[lo[7:4]];
                lo[3:0] = NIB_FWD[lo[3:0]];
                lo[KEY_W-1 -: 5] = lo[KEY_W-1 -: 5] ^ 5'(r);
                k[KEY_W-1:0]      = lo;
                round_keys[r + 1] = lo;
            end
            keys_fresh = 1'b1;
        endfunction

        function logic [HALF_W-1:0] sub_half(logic [HALF_W-1:0] x, bit inv);
            logic [HALF_W-1:0] z;
            for (int n = 0; n < HALF_W / 4; n++)
            begin
                z[n*4 +: 4] = inv ? NIB_INV[x[n*4 +: 4]] : NIB_FWD[x[n*4 +: 4]];
            end
            return z;
        endfunction

        function logic [BLK_W-1:0] cipher(logic op, logic [BLK_W-1:0] b);
            logic [HALF_W-1:0] l;
            logic [HALF_W-1:0] r;
            logic [HALF_W-1:0] s;
            logic [HALF_W-1:0] t;
            logic [KEY_W-1:0]  k;
            if (!keys_fresh)
                build_round_keys();
            l = b[BLK_W-1:HALF_W];
            r = b[HALF_W-1:0];
            if (op == OP_ENC)
            begin
                for (int j = 0; j < N_ROUNDS; j++)
                begin
                    k = round_keys[j];
                    s = sub_half(r, 1'b0);
                    t = s ^ l ^ k[HALF_W-1:0];
                    l = {t[28:0], t[31:29]};       // rotate left 3
                    t = s ^ l ^ k[KEY_W-1:HALF_W];
                    r = {t[6:0], t[31:7]};         // rotate right 7
                    t = r;
                    r = l;
                    l = t;
                end
            end
            else
            begin
                // inverse rounds, last round key first
                for (int j = N_ROUNDS - 1; j >= 0; j--)
                begin
                    k = round_keys[j];
                    t = l;
                    l = r;
                    r = t;
                    r = {r[24:0], r[31:25]} ^ l ^ k[KEY_W-1:HALF_W];
                    l = {l[2:0], l[31:3]} ^ r ^ k[HALF_W-1:0];
                    r = sub_half(r, 1'b1);
                end
            end
            return {l, r};
        endfunction

        function void note_block(logic op, logic [BLK_W-1:0] b);
            expected_blocks.push_back(cipher(op, b));
        endfunction

        function int pending();
            return expected_blocks.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(logic [BLK_W-1:0] got);
            logic [BLK_W-1:0] want;
            if (expected_blocks.size() == 0)
            begin
                report($sformatf("result %h with no block outstanding", got));
            end
            else
            begin
                want = expected_blocks.pop_front();
                if (got !== want)
                    report($sformatf("block_out expected %h got %h", want, got));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [KEY_W-1:0]     cfg_data;

    // quiet: no idling on either side; hold_req: ask the sink for a long hold-off
    bit quiet;
    bit hold_req;
    int cycle_count;

    cipher_scoreboard sb;

    lbc_blk_if blk_ch ();
    lbc_res_if res_ch ();

    lightweight_block_cipher_64_128 #(
        .ROUNDS (N_ROUNDS)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk       (blk_ch),
        .res       (res_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // watchdog: a hang or a lost result ends here
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // both beats are sampled at the rising edge; inputs only move on the falling edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (blk_ch.valid === 1'b1 && blk_ch.ready === 1'b1)
                sb.note_block(blk_ch.mode, blk_ch.block_in);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                sb.check_result(res_ch.block_out);
        end
    end

    // result sink: random stalls, plus one long hold-off counted here so the
    // output register and the input side both back up
    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_ch.ready <= 1'b0;
                hold_left--;
            end
            else
            begin
                res_ch.ready <= quiet || ($urandom_range(99) >= 22);
            end
        end
    end

    function automatic logic [BLK_W-1:0] rand_block();
        return {$urandom(), $urandom()};
    endfunction

    // one input beat; called and returns on a falling edge, valid left high
    task automatic send_block(input logic op, input logic [BLK_W-1:0] data);
        while (!quiet && $urandom_range(99) < 22)
        begin
            blk_ch.valid <= 1'b0;
            @(negedge clk);
        end
        blk_ch.valid    <= 1'b1;
        blk_ch.mode     <= op;
        blk_ch.block_in <= data;
        @(posedge clk);
        while (!(blk_ch.valid === 1'b1 && blk_ch.ready === 1'b1))
            @(posedge clk);
        @(negedge clk);
    endtask

    // one register write; the caller drops the write enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    // every beat yields one result, so an empty scoreboard means the block is idle
    task automatic drain();
        blk_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // a block followed by its inverse under the same key, so the second result
    // must give back the first input
    task automatic send_round_trip(input logic op, input logic [BLK_W-1:0] data);
        logic [BLK_W-1:0] partner;
        partner = sb.cipher(op, data);
        send_block(op, data);
        send_block(~op, partner);
    endtask

    task automatic run_random(input int count);
        int i;
        int pick;
        logic [BLK_W-1:0] data;
        i = 0;
        while (i < count)
        begin
            pick = $urandom_range(99);
            if (pick < 30 && i + 1 < count)
            begin
                send_round_trip(1'($urandom_range(1)), rand_block());
                i += 2;
            end
            else
            begin
                if (pick < 40)
                begin
                    // sparse blocks: a single bit set or cleared
                    data = BLK_W'(1) << $urandom_range(BLK_W - 1);
                    if ($urandom_range(1))
                        data = ~data;
                end
                else
                begin
                    data = rand_block();
                end
                send_block(1'($urandom_range(1)), data);
                i++;
            end
        end
    endtask

    initial
    begin
        sb              = new();
        quiet           = 1'b0;
        hold_req        = 1'b0;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = REG_KEY_UPPER;
        cfg_data        = '0;
        blk_ch.valid    = 1'b0;
        blk_ch.mode     = OP_ENC;
        blk_ch.block_in = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // keys as left by reset (all zero), never written yet
        send_block(OP_ENC, '0);
        send_block(OP_ENC, ALL_ONES);
        send_block(OP_DEC, '0);
        send_block(OP_DEC, ALL_ONES);
        drain();

        // all-ones key; writes to undecoded indexes must leave it alone
        write_reg(REG_KEY_UPPER, ALL_ONES);
        write_reg(REG_KEY_LOWER, ALL_ONES);
        write_reg(REG_SPARE_2, rand_block());
        write_reg(REG_SPARE_3, rand_block());
        cfg_wr_en <= 1'b0;
        send_block(OP_ENC, 64'haaaa_aaaa_aaaa_aaaa);
        send_block(OP_DEC, 64'h5555_5555_5555_5555);
        send_round_trip(OP_ENC, rand_block());
        drain();

        // stale round keys after a write to the lower half only
        write_reg(REG_KEY_LOWER, rand_block());
        cfg_wr_en <= 1'b0;
        send_block(OP_ENC, BLK_W'(1));
        send_block(OP_ENC, BLK_W'(1) << 63);
        send_block(OP_DEC, BLK_W'(1) << 31);
        send_block(OP_DEC, BLK_W'(1) << 32);
        drain();

        // stale round keys after a write to the upper half only
        write_reg(REG_KEY_UPPER, BLK_W'(1) << 63);
        cfg_wr_en <= 1'b0;
        send_round_trip(OP_DEC, rand_block());
        drain();

        // random phases, each under its own key setting
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(REG_KEY_UPPER, rand_block());
                    write_reg(REG_KEY_LOWER, rand_block());
                end
                1:
                begin
                    // no idling on either side through this phase
                    quiet = 1'b1;
                    write_reg(REG_KEY_UPPER, '0);
                    write_reg(REG_KEY_LOWER, ALL_ONES);
                end
                2:
                begin
                    // long sink hold-off while the source keeps offering
                    quiet    = 1'b0;
                    hold_req = 1'b1;
                    write_reg(REG_KEY_UPPER, ALL_ONES);
                    write_reg(REG_KEY_LOWER, '0);
                end
                3:
                begin
                    write_reg(REG_SPARE_3, rand_block());
                    write_reg(REG_KEY_LOWER, rand_block());
                    write_reg(REG_KEY_UPPER, rand_block());
                    write_reg(REG_SPARE_2, rand_block());
                end
                4:
                begin
                    write_reg(REG_KEY_UPPER, rand_block());
                end
                default:
                begin
                    write_reg(REG_KEY_UPPER, rand_block());
                    write_reg(REG_KEY_LOWER, rand_block());
                end
            endcase
            cfg_wr_en <= 1'b0;
            run_random(PHASE_ITEMS);
            drain();
        end

        // let any stray result show up before the verdict
        repeat (N_ROUNDS + 10) @(posedge clk);
        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/lbc_pkg.sv
rtl/core/lbc_blk_if.sv
rtl/core/lbc_res_if.sv
rtl/core/lbc_ctrl.sv
rtl/core/lbc_dp.sv
rtl/core/lightweight_block_cipher_64_128.sv
rtl/core/lbc_checker.sv
tb/sv/lightweight_block_cipher_64_128_test.sv
